// ===== sv/bitstream_header_validator_unit_defines.svh =====
// assertion macros used by the rtl
`ifndef BITSTREAM_HEADER_VALIDATOR_UNIT_DEFINES_SVH
`define BITSTREAM_HEADER_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BHV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BHV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/bhv_pkg.sv =====
package bhv_pkg;

  localparam int MARKER_LEN = 20;
  localparam int SYNC_LEN = 4;
  localparam int MAX_LEN = (MARKER_LEN > SYNC_LEN) ? MARKER_LEN : SYNC_LEN;
  localparam int HIST_LEN = ((MAX_LEN > 2) ? MAX_LEN : 2) - 1;

  localparam int CNT_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] MIN_IMAGE_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] SEARCH_WINDOW_RESET = CFG_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_IMAGE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WINDOW = CFG_IDX_W'(1);

  localparam logic [7:0] MARKER_TAB [MARKER_LEN] = '{
    8'h50, 8'h61, 8'h72, 8'h74, 8'h3A, 8'h20, 8'h69, 8'h43, 8'h45, 8'h34,
    8'h30, 8'h55, 8'h50, 8'h35, 8'h4B, 8'h2D, 8'h53, 8'h47, 8'h34, 8'h38
  };

  localparam logic [7:0] SYNC_TAB [SYNC_LEN] = '{8'h7E, 8'hAA, 8'h99, 8'h7E};

  typedef struct packed {
    logic marker_hit;
    logic sync_hit;
  } hits_t;

endpackage

// ===== sv/bhv_scan.sv =====
module bhv_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          clear,
  input  logic [7:0]    image_byte,
  output bhv_pkg::hits_t hits
);
  import bhv_pkg::*;

  logic [7:0] hist [HIST_LEN];
  logic [7:0] win [HIST_LEN+1];
  logic       marker_hit;
  logic       sync_hit;

  // newest byte first
  always_comb begin
    win[0] = image_byte;
    for (int i = 1; i <= HIST_LEN; i++) begin
      win[i] = hist[i-1];
    end
  end

  always_comb begin
    marker_hit = 1'b1;
    for (int k = 0; k < MARKER_LEN; k++) begin
      if (win[MARKER_LEN-1-k] != MARKER_TAB[k]) begin
        marker_hit = 1'b0;
      end
    end
  end

  always_comb begin
    sync_hit = 1'b1;
    for (int k = 0; k < SYNC_LEN; k++) begin
      if (win[SYNC_LEN-1-k] != SYNC_TAB[k]) begin
        sync_hit = 1'b0;
      end
    end
  end

  assign hits.marker_hit = marker_hit;
  assign hits.sync_hit = sync_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist[i] <= 8'h00;
      end
    end else if (shift) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist[i] <= clear ? 8'h00 : win[i];
      end
    end
  end

endmodule

// ===== sv/bitstream_header_validator_unit.sv =====
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------
// input    | in_valid  | in_stall  | image_byte, is_last
// output   | out_valid | out_stall | status, sync_start
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// one byte per cycle while in_stall is low; a result is registered once its last byte leaves the input register
// the input register and the result register sit around the window compare
// rst is synchronous and clears registers to 1024/1024 and the image state
// in_stall rises only while a last byte waits for a stalled result register
`include "bitstream_header_validator_unit_defines.svh"

module bitstream_header_validator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    image_byte,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [15:0]                   sync_start,
  input  logic                          cfg_we,
  input  logic [bhv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bhv_pkg::CFG_W-1:0]     cfg_data
);
  import bhv_pkg::*;

  logic [CFG_W-1:0] min_image_bytes;
  logic [CFG_W-1:0] search_window_bytes;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic             marker_seen;
  logic             marker_seen_next;
  logic [CNT_W-1:0] marker_position;
  logic [CNT_W-1:0] marker_position_next;
  logic             sync_seen;
  logic             sync_seen_next;
  logic [CNT_W-1:0] sync_position;
  logic [CNT_W-1:0] sync_position_next;

  logic             proc;
  logic             load;
  logic [CNT_W:0]   received;
  logic             marker_ok;
  logic             sync_ok;
  logic             image_ok;
  hits_t            hits;

  assign proc = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign load = !s1_valid || proc;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_image_bytes <= MIN_IMAGE_RESET;
      search_window_bytes <= SEARCH_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_IMAGE:     min_image_bytes <= cfg_data;
        REG_SEARCH_WINDOW: search_window_bytes <= cfg_data;
        default:           ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      s1_byte <= image_byte;
      s1_last <= is_last;
    end
  end

  bhv_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .shift      (proc),
    .clear      (s1_last),
    .image_byte (s1_byte),
    .hits       (hits)
  );

  assign received = {1'b0, byte_count} + (CNT_W+1)'(1);

  always_comb begin
    byte_count_next = (byte_count == CNT_MAX) ? byte_count : received[CNT_W-1:0];

    marker_ok = !marker_seen && hits.marker_hit
      && (received >= (CNT_W+1)'(MARKER_LEN))
      && (received <= {1'b0, search_window_bytes});
    sync_ok = !sync_seen && hits.sync_hit
      && (received >= (CNT_W+1)'(SYNC_LEN))
      && (received <= {1'b0, search_window_bytes});

    marker_seen_next = marker_seen || marker_ok;
    marker_position_next = marker_ok ? received[CNT_W-1:0] - CNT_W'(MARKER_LEN)
                                     : marker_position;
    sync_seen_next = sync_seen || sync_ok;
    sync_position_next = sync_ok ? received[CNT_W-1:0] - CNT_W'(SYNC_LEN)
                                 : sync_position;

    image_ok = (byte_count_next >= min_image_bytes) && marker_seen_next
      && sync_seen_next && (marker_position_next < sync_position_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      marker_seen <= 1'b0;
      marker_position <= '0;
      sync_seen <= 1'b0;
      sync_position <= '0;
    end else if (proc) begin
      if (s1_last) begin
        byte_count <= '0;
        marker_seen <= 1'b0;
        marker_position <= '0;
        sync_seen <= 1'b0;
        sync_position <= '0;
      end else begin
        byte_count <= byte_count_next;
        marker_seen <= marker_seen_next;
        marker_position <= marker_position_next;
        sync_seen <= sync_seen_next;
        sync_position <= sync_position_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_last) begin
      status <= !image_ok;
      sync_start <= image_ok ? sync_position_next : '0;
    end
  end

  `BHV_ASSERT_IMP(a_bad_zero_offset, clk, rst, out_valid && status, sync_start == '0)
  `BHV_ASSERT_IMP(a_stall_on_last, clk, rst, in_stall, s1_valid && s1_last && out_valid)
  `BHV_ASSERT_NXT(a_clear_after_last, clk, rst, proc && s1_last,
    byte_count == '0 && !marker_seen && !sync_seen && out_valid)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bhv_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int IMAGE_TARGET = 24;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 10;
  localparam int EDGE_WINDOW = 48;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = CFG_IDX_W'(3);

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic        status;
    logic [15:0] offset;
  } verdict_t;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       image_byte = 8'h00;
  logic             is_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             status;
  logic [15:0]      sync_start;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bitstream_header_validator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .image_byte(image_byte),
    .is_last(is_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .sync_start(sync_start),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // expected image verdicts, oldest first
  verdict_t verdict_q[$];
  int fail_count = 0;

  // shadow of the block's image state and registers
  logic [7:0]       recent [MAX_LEN];
  logic [15:0]      seen_bytes = '0;
  logic             marker_found = 1'b0;
  logic [15:0]      marker_at = '0;
  logic             sync_found = 1'b0;
  logic [15:0]      sync_at = '0;
  logic [CFG_W-1:0] min_bytes_reg = MIN_IMAGE_RESET;
  logic [CFG_W-1:0] window_reg = SEARCH_WINDOW_RESET;

  logic [7:0] image_buf[$];

  int burst_left = 0;
  int max_gap = 8;
  int hold_requests = 0;
  int hold_grants = 0;
  int hold_left = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int idle_cycles = 0;

  initial begin
    for (int k = 0; k < MAX_LEN; k++) recent[k] = 8'h00;
  end

  task automatic report_error(input string what);
    $display("[%0t] ERROR %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_image_model();
    int k;
    for (k = 0; k < MAX_LEN; k++) recent[k] = 8'h00;
    seen_bytes = '0;
    marker_found = 1'b0;
    marker_at = '0;
    sync_found = 1'b0;
    sync_at = '0;
  endtask

  task automatic track_image_byte(input logic [7:0] b, input logic last);
    int k;
    logic [16:0] rcv;
    logic hit;
    logic ok;
    verdict_t v;
    for (k = MAX_LEN - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = b;
    rcv = {1'b0, seen_bytes} + 17'd1;
    if (seen_bytes != CNT_MAX) seen_bytes = seen_bytes + 16'd1;

    if (!marker_found && rcv >= MARKER_LEN && rcv <= {1'b0, window_reg}) begin
      hit = 1'b1;
      for (k = 0; k < MARKER_LEN; k++)
        if (recent[MARKER_LEN-1-k] != MARKER_TAB[k]) hit = 1'b0;
      if (hit) begin
        marker_found = 1'b1;
        marker_at = 16'(rcv - MARKER_LEN);
      end
    end
    if (!sync_found && rcv >= SYNC_LEN && rcv <= {1'b0, window_reg}) begin
      hit = 1'b1;
      for (k = 0; k < SYNC_LEN; k++)
        if (recent[SYNC_LEN-1-k] != SYNC_TAB[k]) hit = 1'b0;
      if (hit) begin
        sync_found = 1'b1;
        sync_at = 16'(rcv - SYNC_LEN);
      end
    end

    if (last) begin
      ok = (seen_bytes >= min_bytes_reg) && marker_found && sync_found &&
           (marker_at < sync_at);
      v.status = ok ? STATUS_GOOD : STATUS_BAD;
      v.offset = ok ? sync_at : 16'd0;
      verdict_q.push_back(v);
      clear_image_model();
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0 || max_gap == 0) ? 0 : $urandom_range(1, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    image_byte <= b;
    is_last <= last;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    track_image_byte(b, last);
    @(negedge clk);
  endtask

  task automatic drive_image();
    for (int i = 0; i < image_buf.size(); i++)
      send_byte(image_buf[i], i == image_buf.size() - 1);
  endtask

  // random fill with the marker and the sync word placed where asked; -1 leaves one out
  task automatic make_image(input int len, input int mk_pos, input int sy_pos);
    int k;
    image_buf.delete();
    for (k = 0; k < len; k++) image_buf.push_back(8'($urandom_range(0, 255)));
    if (mk_pos >= 0)
      for (k = 0; k < MARKER_LEN; k++) image_buf[mk_pos + k] = MARKER_TAB[k];
    if (sy_pos >= 0)
      for (k = 0; k < SYNC_LEN; k++) image_buf[sy_pos + k] = SYNC_TAB[k];
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_IMAGE: min_bytes_reg = data;
      REG_SEARCH_WINDOW: window_reg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // receiver: random stall patterns, plus long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_grants != hold_requests) begin
      hold_grants++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) != 0);
        RX_TOGGLE: out_stall <= ~out_stall;
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_error($sformatf("unexpected result status=%0d sync_start=%0d",
                               status, sync_start));
      end else begin
        want = verdict_q.pop_front();
        if (status !== want.status)
          report_error($sformatf("status got %0d want %0d", status, want.status));
        if (sync_start !== want.offset)
          report_error($sformatf("sync_start got %0d want %0d", sync_start, want.offset));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] timeout, %0d results outstanding", $time, verdict_q.size());
      $display("bitstream_header_validator_unit: mismatch");
      $finish;
    end
  end

  task automatic test_short_images();
    image_buf = '{8'h7E};
    drive_image();
    image_buf = '{SYNC_TAB[0], SYNC_TAB[1], SYNC_TAB[2]};
    drive_image();
    wait_idle();
  endtask

  task automatic test_minimal_image();
    write_register(REG_MIN_IMAGE, CFG_W'(MARKER_LEN + SYNC_LEN));
    write_register(REG_SEARCH_WINDOW, CFG_W'(MARKER_LEN + SYNC_LEN));
    make_image(MARKER_LEN + SYNC_LEN, 0, MARKER_LEN);
    drive_image();
    wait_idle();
  endtask

  task automatic test_backpressure();
    int saved_gap;
    saved_gap = max_gap;
    write_register(REG_MIN_IMAGE, 16'd0);
    write_register(REG_SEARCH_WINDOW, 16'hFFFF);
    max_gap = 0;
    hold_requests++;
    for (int i = 0; i < 16; i++) begin
      make_image($urandom_range(1, 3), -1, -1);
      drive_image();
    end
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      make_image(MARKER_LEN + SYNC_LEN + $urandom_range(0, 4), 0, MARKER_LEN);
      drive_image();
    end
    max_gap = saved_gap;
    wait_idle();
  endtask

  task automatic pick_setting();
    logic [CFG_W-1:0] v;
    if ($urandom_range(0, 3) == 0)
      write_register($urandom_range(0, 1) ? REG_UNMAPPED_2 : REG_UNMAPPED_3,
                     CFG_W'($urandom_range(0, 65535)));
    case ($urandom_range(0, 7))
      0: v = 16'd0;
      1: v = 16'd1;
      2: v = 16'hFFFF;
      default: v = CFG_W'($urandom_range(0, 64));
    endcase
    write_register(REG_MIN_IMAGE, v);
    case ($urandom_range(0, 7))
      0: v = 16'd0;
      1: v = 16'd1;
      2: v = 16'hFFFF;
      default: v = CFG_W'($urandom_range(0, 72));
    endcase
    write_register(REG_SEARCH_WINDOW, v);
  endtask

  task automatic test_random_images();
    int bytes_sent;
    int images_sent;
    int until_change;
    int len;
    int mk;
    int sy;
    int pick;
    int k;
    bytes_sent = 0;
    images_sent = 0;
    until_change = 0;
    while (bytes_sent < ITEM_TARGET || images_sent < IMAGE_TARGET) begin
      if (until_change == 0) begin
        wait_idle();
        pick_setting();
        until_change = $urandom_range(3, 8);
        max_gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      end
      until_change--;
      pick = $urandom_range(0, 9);
      len = $urandom_range(MARKER_LEN + SYNC_LEN, 64);
      if (pick <= 6) begin
        mk = $urandom_range(0, len - MARKER_LEN - SYNC_LEN);
        sy = $urandom_range(mk + MARKER_LEN, len - SYNC_LEN);
        make_image(len, mk, sy);
      end else if (pick == 7) begin
        // sync word ahead of the marker
        sy = $urandom_range(0, len - MARKER_LEN - SYNC_LEN);
        mk = $urandom_range(sy + SYNC_LEN, len - MARKER_LEN);
        make_image(len, mk, sy);
      end else if (pick == 8) begin
        mk = $urandom_range(0, len - MARKER_LEN - SYNC_LEN);
        sy = $urandom_range(mk + MARKER_LEN, len - SYNC_LEN);
        make_image(len, mk, sy);
        k = $urandom_range(0, 1) ? mk + $urandom_range(0, MARKER_LEN - 1)
                                 : sy + $urandom_range(0, SYNC_LEN - 1);
        image_buf[k] = image_buf[k] ^ (8'd1 << $urandom_range(0, 7));
      end else begin
        // noise leaning on sync bytes
        len = $urandom_range(1, 40);
        image_buf.delete();
        for (k = 0; k < len; k++)
          image_buf.push_back($urandom_range(0, 1) ? SYNC_TAB[$urandom_range(0, SYNC_LEN - 1)]
                                                   : 8'($urandom_range(0, 255)));
      end
      bytes_sent += image_buf.size();
      images_sent++;
      drive_image();
    end
    wait_idle();
  endtask

  task automatic test_window_edge();
    int saved_gap;
    saved_gap = max_gap;
    max_gap = 0;
    write_register(REG_MIN_IMAGE, 16'd0);
    write_register(REG_SEARCH_WINDOW, CFG_W'(EDGE_WINDOW));
    // sync word ending on the last byte the window allows
    make_image(EDGE_WINDOW + 8, 0, EDGE_WINDOW - SYNC_LEN);
    drive_image();
    // one byte later it falls outside
    make_image(EDGE_WINDOW + 8, 0, EDGE_WINDOW - SYNC_LEN + 1);
    drive_image();
    max_gap = saved_gap;
    wait_idle();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_short_images();
    test_minimal_image();
    test_backpressure();
    test_random_images();
    test_window_edge();
    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("bitstream_header_validator_unit: match");
    end else begin
      $display("bitstream_header_validator_unit: mismatch");
    end
    $finish;
  end

endmodule
